>>> hw/rtl/bfn_pkg.sv
// ----------------------------------------------------------------------------
// Band frame normalizer package
// Shared widths, defaults, register map, queue entry and sequencer state types.
// ----------------------------------------------------------------------------
package bfn_pkg;

   localparam int DEF_BANDS    = 7;
   localparam int DEF_HISTORY  = 20;
   localparam int QUEUE_DEPTH  = 4;

   localparam int SAMPLE_W     = 10;
   localparam int LEVEL_W      = 8;
   localparam int BAND_PORT_W  = 4;
   localparam int THRESH_W     = 14;
   localparam int DIV_STEPS    = LEVEL_W;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = '1;
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = '1;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd500;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD = '0;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
      logic [SAMPLE_W-1:0] fmax;
      logic [SAMPLE_W-1:0] fmin;
      logic                active;
   } queue_entry_type;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_HIST_WR,
      ST_SCAN,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } back_state_type;

endpackage

>>> hw/rtl/bfn_front.sv
// ----------------------------------------------------------------------------
// Band frame normalizer front end
// Accepts samples, tracks the band position and the running frame statistics.
// ----------------------------------------------------------------------------
module bfn_front #(
   parameter int BANDS = bfn_pkg::DEF_BANDS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [bfn_pkg::SAMPLE_W-1:0]    sample,
   input  logic [bfn_pkg::THRESH_W-1:0]    threshold,
   output bfn_pkg::queue_entry_type        entry
);
   import bfn_pkg::*;

   localparam int BAND_W = $clog2(BANDS);
   localparam int SUM_W  = $clog2(BANDS * ((1 << SAMPLE_W) - 1) + 1);
   localparam int CMP_W  = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;

   logic [BAND_W-1:0]   fill_ff, fill_in;
   logic [SAMPLE_W-1:0] run_max_ff, run_max_in;
   logic [SAMPLE_W-1:0] run_min_ff, run_min_in;
   logic [SUM_W-1:0]    run_sum_ff, run_sum_in;
   logic                first, last;
   logic [SAMPLE_W-1:0] base_max, base_min;
   logic [SUM_W-1:0]    base_sum;

   always_comb begin
      first      = (fill_ff == '0);
      last       = (fill_ff == BAND_W'(BANDS - 1));
      base_max   = first ? '0 : run_max_ff;
      base_min   = first ? SAMPLE_MAX : run_min_ff;
      base_sum   = first ? '0 : run_sum_ff;
      run_max_in = (sample > base_max) ? sample : base_max;
      run_min_in = (sample < base_min) ? sample : base_min;
      run_sum_in = base_sum + SUM_W'(sample);
      fill_in    = last ? '0 : fill_ff + 1'b1;

      entry.sample = sample;
      entry.last   = last;
      entry.fmax   = run_max_in;
      entry.fmin   = run_min_in;
      entry.active = CMP_W'(run_sum_in) > CMP_W'(threshold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         run_max_ff <= run_max_in;
         run_min_ff <= run_min_in;
         run_sum_ff <= run_sum_in;
      end
   end

endmodule

>>> hw/rtl/bfn_queue.sv
// ----------------------------------------------------------------------------
// Band frame normalizer queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module bfn_queue #(
   parameter int DEPTH = bfn_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  bfn_pkg::queue_entry_type push_data,
   output logic                     full,
   input  logic                     pop_valid,
   output bfn_pkg::queue_entry_type pop_data,
   output logic                     empty
);
   import bfn_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      empty     = (count_ff == '0);
      do_push   = push_valid && !full;
      do_pop    = pop_valid && !empty;
      pop_data  = slot_ff[rd_ptr_ff];
      wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/bfn_back.sv
// ----------------------------------------------------------------------------
// Band frame normalizer back end
// Gathers a frame, updates the history ring, scans it and divides each band.
// ----------------------------------------------------------------------------
module bfn_back #(
   parameter int BANDS   = bfn_pkg::DEF_BANDS,
   parameter int HISTORY = bfn_pkg::DEF_HISTORY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  bfn_pkg::queue_entry_type          q_data,
   output logic                              q_pop,
   input  logic                              out_pop,
   output logic                              out_valid,
   output logic [bfn_pkg::LEVEL_W-1:0]       out_level,
   output logic [bfn_pkg::BAND_PORT_W-1:0]   out_band,
   output logic                              out_active,
   output logic                              out_last
);
   import bfn_pkg::*;

   localparam int BAND_W = $clog2(BANDS);
   localparam int HIST_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
   localparam int STEP_W = $clog2(DIV_STEPS);

   back_state_type      state_ff, state_in;
   logic [SAMPLE_W-1:0] store_ff [BANDS];
   logic [SAMPLE_W-1:0] max_hist_ff [HISTORY];
   logic [SAMPLE_W-1:0] min_hist_ff [HISTORY];
   logic [HIST_W-1:0]   slot_ff, slot_in;
   logic [HIST_W-1:0]   scan_ff, scan_in;
   logic [BAND_W-1:0]   band_ff, band_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SAMPLE_W-1:0] fmax_ff, fmax_in;
   logic [SAMPLE_W-1:0] fmin_ff, fmin_in;
   logic                act_ff, act_in;
   logic [SAMPLE_W-1:0] gmax_ff, gmax_in;
   logic [SAMPLE_W-1:0] gmin_ff, gmin_in;
   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [LEVEL_W-1:0]  quot_ff, quot_in;
   logic                out_valid_ff, out_valid_in;
   logic [LEVEL_W-1:0]  out_level_ff;
   logic [BAND_W-1:0]   out_band_ff;
   logic                out_active_ff, out_last_ff;
   logic                store_we, hist_we, out_load;
   logic [SAMPLE_W-1:0] range_w, cur_sample, diff_w, hmax_w, hmin_w;
   logic [SAMPLE_W:0]   rem_x2;
   logic                quot_bit;

   always_comb begin
      range_w    = (gmax_ff >= gmin_ff) ? gmax_ff - gmin_ff : '0;
      cur_sample = store_ff[band_ff];
      diff_w     = cur_sample - gmin_ff;
      hmax_w     = max_hist_ff[scan_ff];
      hmin_w     = min_hist_ff[scan_ff];
      rem_x2     = {rem_ff, 1'b0};
      quot_bit   = rem_x2 >= {1'b0, range_w};
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      scan_in      = scan_ff;
      band_in      = band_ff;
      step_in      = step_ff;
      fmax_in      = fmax_ff;
      fmin_in      = fmin_ff;
      act_in       = act_ff;
      gmax_in      = gmax_ff;
      gmin_in      = gmin_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      out_valid_in = out_valid_ff && !out_pop;
      q_pop        = 1'b0;
      store_we     = 1'b0;
      hist_we      = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               store_we = 1'b1;
               if (q_data.last) begin
                  band_in  = '0;
                  fmax_in  = q_data.fmax;
                  fmin_in  = q_data.fmin;
                  act_in   = q_data.active;
                  state_in = ST_HIST_WR;
               end else begin
                  band_in = band_ff + 1'b1;
               end
            end
         end
         ST_HIST_WR: begin
            hist_we  = 1'b1;
            slot_in  = (slot_ff == HIST_W'(HISTORY - 1)) ? '0 : slot_ff + 1'b1;
            scan_in  = '0;
            gmax_in  = '0;
            gmin_in  = SAMPLE_MAX;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (hmax_w > gmax_ff) begin
               gmax_in = hmax_w;
            end
            if (hmin_w < gmin_ff) begin
               gmin_in = hmin_w;
            end
            if (scan_ff == HIST_W'(HISTORY - 1)) begin
               state_in = ST_LOAD;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            step_in = '0;
            rem_in  = diff_w;
            quot_in = '0;
            if (range_w == '0 || cur_sample < gmin_ff) begin
               state_in = ST_EMIT;
            end else if (diff_w >= range_w) begin
               quot_in  = LEVEL_MAX;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = quot_bit ? SAMPLE_W'(rem_x2 - {1'b0, range_w}) : rem_x2[SAMPLE_W-1:0];
            quot_in = {quot_ff[LEVEL_W-2:0], quot_bit};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || out_pop) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               if (band_ff == BAND_W'(BANDS - 1)) begin
                  band_in  = '0;
                  state_in = ST_COLLECT;
               end else begin
                  band_in  = band_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         slot_ff      <= '0;
         band_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < HISTORY; i++) begin
            max_hist_ff[i] <= '0;
            min_hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         band_ff      <= band_in;
         out_valid_ff <= out_valid_in;
         if (hist_we) begin
            max_hist_ff[slot_ff] <= fmax_ff;
            min_hist_ff[slot_ff] <= fmin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      step_ff <= step_in;
      fmax_ff <= fmax_in;
      fmin_ff <= fmin_in;
      act_ff  <= act_in;
      gmax_ff <= gmax_in;
      gmin_ff <= gmin_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (store_we) begin
         store_ff[band_ff] <= q_data.sample;
      end
      if (out_load) begin
         out_level_ff  <= quot_ff;
         out_band_ff   <= band_ff;
         out_active_ff <= act_ff;
         out_last_ff   <= (band_ff == BAND_W'(BANDS - 1));
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_level  = out_level_ff;
   assign out_band   = BAND_PORT_W'(out_band_ff);
   assign out_active = out_active_ff;
   assign out_last   = out_last_ff;

endmodule

>>> hw/rtl/band_frame_normalizer.sv
// ----------------------------------------------------------------------------
// Band frame normalizer
// Scales each band of a frame against the max/min history of recent frames.
// ----------------------------------------------------------------------------
// Samples enter on push/full, one band per beat, bands in order. Every
// BANDS-th beat closes a frame. A frame produces BANDS result beats on the
// empty/pop side, one per band, each with the scaled level, the band index,
// the activity flag and a last marker on the final band.
// The front end takes a beat every cycle while the four-entry queue has
// room. The back end drains one frame, writes the history ring, scans all
// HISTORY slots, and then handles each band in turn: load, an eight-step
// serial divider where needed, and hand-off to the output register.
// A stalled receiver holds the output register, which stops the divider;
// the queue then fills and full rises. Reset clears the history ring, the
// band position, the queue and the output, and sets the threshold to 500.
// ----------------------------------------------------------------------------
module band_frame_normalizer #(
   parameter int BANDS   = bfn_pkg::DEF_BANDS,
   parameter int HISTORY = bfn_pkg::DEF_HISTORY
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [bfn_pkg::SAMPLE_W-1:0]      req_sample,
   output logic                              empty,
   input  logic                              pop,
   output logic [bfn_pkg::LEVEL_W-1:0]       rsp_level,
   output logic [bfn_pkg::BAND_PORT_W-1:0]   rsp_band,
   output logic                              rsp_active,
   output logic                              rsp_last,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bfn_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bfn_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bfn_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import bfn_pkg::*;

   logic [THRESH_W-1:0]    threshold_ff;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic                   csr_write, push_accept, q_full, q_empty, q_pop, out_valid;
   queue_entry_type        front_entry, q_data;

   assign pready      = 1'b1;
   assign csr_index   = paddr[CSR_ADDR_W-1:2];
   assign csr_write   = psel && penable && pwrite && pready;
   assign prdata      = (csr_index == REG_THRESHOLD) ? CSR_DATA_W'(threshold_ff) : '0;
   assign full        = q_full;
   assign push_accept = push && !q_full;
   assign empty       = !out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else if (csr_write && csr_index == REG_THRESHOLD) begin
         threshold_ff <= pwdata[THRESH_W-1:0];
      end
   end

   bfn_front #(
      .BANDS     (BANDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (push_accept),
      .sample    (req_sample),
      .threshold (threshold_ff),
      .entry     (front_entry)
   );

   bfn_queue #(
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push),
      .push_data  (front_entry),
      .full       (q_full),
      .pop_valid  (q_pop),
      .pop_data   (q_data),
      .empty      (q_empty)
   );

   bfn_back #(
      .BANDS      (BANDS),
      .HISTORY    (HISTORY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .out_pop    (pop),
      .out_valid  (out_valid),
      .out_level  (rsp_level),
      .out_band   (rsp_band),
      .out_active (rsp_active),
      .out_last   (rsp_last)
   );

endmodule
